// ===== src/pei_pkg.sv =====
// Shared types and constants for the polygon edge intersection unit.
// No dependencies.
package pei_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_TEST   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RA0, S_RA1, S_RB0, S_RB1, S_CAP, S_MGO, S_MWT, S_NORM,
    S_TEST, S_MIN, S_PICK, S_RDP, S_BS, S_KK, S_NEXT, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_D0, OP_D1, OP_T0, OP_T1, OP_U0, OP_U1, OP_SX, OP_SY, OP_C2, OP_KK
  } op_t;

  // multiplier: 67-bit multiplicand, 33-bit multiplier in 8-bit digits
  localparam int MA_W       = 67;
  localparam int MB_W       = 33;
  localparam int DIG_W      = 8;
  localparam int MUL_DIGITS = 5;
  localparam int MP_W       = MA_W + MUL_DIGITS * DIG_W - 7;  // 100

  localparam logic [14:0] Q_ONE = 15'd16384;

endpackage

// ===== src/pei_mul.sv =====
// Iterative unsigned multiplier, one 8-bit digit of b per cycle, MSB first.
// Depends on pei_pkg.
module pei_mul
  import pei_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MA_W-1:0]   a,
  input  logic [MB_W-1:0]   b,
  output logic              done,
  output logic [MP_W-1:0]   p
);

  localparam int BW = MUL_DIGITS * DIG_W;

  logic [MA_W-1:0]  a_r;
  logic [BW-1:0]    b_r;
  logic [MP_W-1:0]  acc_r;
  logic [2:0]       cnt_r;
  logic             run_r;
  logic             done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(MUL_DIGITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= BW'(b);
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= (acc_r << DIG_W) + MP_W'(a_r * b_r[BW-1 -: DIG_W]);
      b_r   <= b_r << DIG_W;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ===== src/polygon_edge_intersection_unit.sv =====
// Polygon edge-pair intersection unit: vertex store, edge walk sequencer,
// exact crossing test and Q1.14 normal rounding. Depends on pei_pkg, pei_mul.
//
//  channel | direction | beat contents
//  in_     | input     | command, polygon_sel, vertex_x, vertex_y
//  out_    | output    | hit, dir_x, dir_y, start_x, start_y, overflow
//
// Append and clear beats are taken back to back while idle; they give no result.
// A test beat walks the edge pairs until the first crossing: four store reads
// through one read port, up to six multiplies on the shared five-digit
// multiplier (each: issue, five digits, done) and two or three compare steps;
// a parallel pair stops after the first two multiplies. A hit adds the pick,
// one store read and about 30 binary-search steps to round the normal.
// Reset (synchronous, rst_n low) empties both polygons and the drop flag; the
// store itself is not cleared. in_ready is low while a test runs; a finished
// result waits in the output register, and appends are taken meanwhile.
module polygon_edge_intersection_unit
  import pei_pkg::*;
#(
  parameter int MAX_VERTICES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic               in_polygon_sel,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [31:0] out_start_x,
  output logic signed [31:0] out_start_y,
  output logic               out_overflow
);

  localparam int DEPTH = 2 * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam logic [AW-1:0] B_BASE = AW'(MAX_VERTICES);

  function automatic logic [32:0] mag34(input logic signed [33:0] v);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    return m[32:0];
  endfunction

  // ---------------- state ----------------
  state_t state_r, state_nxt;
  op_t    op_r;

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_q_r;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] cnt_a_r, cnt_b_r;
  logic          dropped_r;
  logic [IW-1:0] i_r, j_r;

  logic [63:0] pa0_r, pa1_r, pb0_r, pb1_r;
  logic signed [67:0] acc_r, d_r, tn_r, un_r, rt_r, ru_r, mt_r, mu_r;
  logic signed [33:0] vx_r, vy_r;
  logic [AW-1:0]      pick_r;
  logic               neg_r, comp_r;
  logic [MA_W-1:0]    s_r;
  logic [95:0]        rhs_r;
  logic [14:0]        lo_r, hi_r, mid_r;
  logic [31:0]        kk_r;

  logic               hit_r, ovf_r;
  logic signed [15:0] dir_x_r, dir_y_r;
  logic [63:0]        start_r;

  logic               out_valid_r, out_hit_r, out_ovf_r;
  logic signed [15:0] out_dir_x_r, out_dir_y_r;
  logic [31:0]        out_start_x_r, out_start_y_r;

  // ---------------- edge geometry ----------------
  logic signed [32:0] eax, eay, ebx, eby, dxv, dyv;
  assign eax = $signed({pa1_r[31], pa1_r[31:0]})  - $signed({pa0_r[31], pa0_r[31:0]});
  assign eay = $signed({pa1_r[63], pa1_r[63:32]}) - $signed({pa0_r[63], pa0_r[63:32]});
  assign ebx = $signed({pb1_r[31], pb1_r[31:0]})  - $signed({pb0_r[31], pb0_r[31:0]});
  assign eby = $signed({pb1_r[63], pb1_r[63:32]}) - $signed({pb0_r[63], pb0_r[63:32]});
  assign dxv = $signed({pb0_r[31], pb0_r[31:0]})  - $signed({pa0_r[31], pa0_r[31:0]});
  assign dyv = $signed({pb0_r[63], pb0_r[63:32]}) - $signed({pa0_r[63], pa0_r[63:32]});

  // wrapped edge end indices
  logic [IW-1:0] i1, j1;
  logic          i_last, j_last;
  assign i_last = (CW'(i_r) + CW'(1)) >= cnt_a_r;
  assign j_last = (CW'(j_r) + CW'(1)) >= cnt_b_r;
  assign i1 = i_last ? '0 : i_r + IW'(1);
  assign j1 = j_last ? '0 : j_r + IW'(1);

  logic [AW-1:0] ia, ia1, ib, ib1;
  assign ia  = AW'(i_r);
  assign ia1 = AW'(i1);
  assign ib  = B_BASE + AW'(j_r);
  assign ib1 = B_BASE + AW'(j1);

  // ---------------- shared multiplier ----------------
  logic              mul_start, mul_done, mul_neg;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;
  logic signed [33:0] opa, opb, comp_v;

  assign comp_v = comp_r ? vy_r : vx_r;

  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      OP_D0:   begin opa = 34'(eax); opb = 34'(eby); end
      OP_D1:   begin opa = 34'(eay); opb = 34'(ebx); end
      OP_T0:   begin opa = 34'(dxv); opb = 34'(eby); end
      OP_T1:   begin opa = 34'(dyv); opb = 34'(ebx); end
      OP_U0:   begin opa = 34'(dxv); opb = 34'(eay); end
      OP_U1:   begin opa = 34'(dyv); opb = 34'(eax); end
      OP_SX:   begin opa = vx_r;     opb = vx_r;     end
      OP_SY:   begin opa = vy_r;     opb = vy_r;     end
      OP_C2:   begin opa = comp_v;   opb = comp_v;   end
      default: begin opa = '0;       opb = '0;       end
    endcase
  end

  assign mul_a   = (op_r == OP_KK) ? s_r : MA_W'(mag34(opa));
  assign mul_b   = (op_r == OP_KK) ? MB_W'(kk_r) : mag34(opb);
  assign mul_neg = (op_r == OP_KK) ? 1'b0 : (opa[33] ^ opb[33]);

  pei_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  logic signed [67:0] sp;
  assign sp = neg_r ? -$signed({1'b0, mul_p[66:0]}) : $signed({1'b0, mul_p[66:0]});

  // ---------------- decisions ----------------
  logic signed [67:0] d_diff, un2, tn2;
  logic               d_zero, cross_ok, b_side, bs_more, kk_fits;
  logic [14:0]        mid;
  logic [15:0]        kodd;
  logic signed [15:0] qv;

  assign d_diff  = acc_r - sp;
  assign d_zero  = (d_diff == '0);
  assign cross_ok = !tn_r[67] && (tn_r != '0) && (tn_r < d_r) &&
                    !un_r[67] && (un_r != '0) && (un_r < d_r);
  assign b_side  = mu_r < mt_r;
  assign un2     = un_r <<< 1;
  assign tn2     = tn_r <<< 1;
  assign bs_more = lo_r < hi_r;
  assign mid     = 15'((16'(lo_r) + 16'(hi_r) + 16'd1) >> 1);
  assign kodd    = {mid_r, 1'b0} - 16'd1;
  assign kk_fits = mul_p <= MP_W'(rhs_r);
  assign qv      = comp_v[33] ? -$signed({1'b0, lo_r}) : $signed({1'b0, lo_r});

  logic accept, out_free;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_TEST) begin
          state_nxt = (cnt_a_r == '0 || cnt_b_r == '0) ? S_FIN : S_RA0;
        end
      end
      S_RA0:  state_nxt = S_RA1;
      S_RA1:  state_nxt = S_RB0;
      S_RB0:  state_nxt = S_RB1;
      S_RB1:  state_nxt = S_CAP;
      S_CAP:  state_nxt = S_MGO;
      S_MGO:  state_nxt = S_MWT;
      S_MWT: begin
        if (mul_done) begin
          case (op_r)
            OP_D1:   state_nxt = d_zero ? S_NEXT : S_MGO;
            OP_U1:   state_nxt = S_NORM;
            OP_C2:   state_nxt = S_BS;
            OP_KK:   state_nxt = S_BS;
            default: state_nxt = S_MGO;
          endcase
        end
      end
      S_NORM: state_nxt = S_TEST;
      S_TEST: state_nxt = cross_ok ? S_MIN : S_NEXT;
      S_MIN:  state_nxt = S_PICK;
      S_PICK: state_nxt = S_RDP;
      S_RDP:  state_nxt = S_MGO;
      S_BS: begin
        if (bs_more)     state_nxt = S_KK;
        else if (comp_r) state_nxt = S_FIN;
        else             state_nxt = S_MGO;
      end
      S_KK:   state_nxt = S_MGO;
      S_NEXT: state_nxt = (j_last && i_last) ? S_FIN : S_RA0;
      S_FIN:  state_nxt = out_free ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mul_start = (state_r == S_MGO);
    case (state_r)
      S_RA0:   rd_addr = ia;
      S_RA1:   rd_addr = ia1;
      S_RB0:   rd_addr = ib;
      S_RB1:   rd_addr = ib1;
      default: rd_addr = pick_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- vertex store ----------------
  logic          cnt_room;
  logic [CW-1:0] cnt_sel;
  assign cnt_sel  = in_polygon_sel ? cnt_b_r : cnt_a_r;
  assign cnt_room = cnt_sel < CW'(MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_APPEND && cnt_room) begin
      mem[in_polygon_sel ? B_BASE + AW'(cnt_sel) : AW'(cnt_sel)] <=
        {in_vertex_y, in_vertex_x};
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r   <= '0;
      cnt_b_r   <= '0;
      dropped_r <= 1'b0;
    end else if (accept) begin
      case (in_command)
        CMD_APPEND: begin
          if (!cnt_room)           dropped_r <= 1'b1;
          else if (in_polygon_sel) cnt_b_r <= cnt_b_r + CW'(1);
          else                     cnt_a_r <= cnt_a_r + CW'(1);
        end
        CMD_CLEAR: begin
          dropped_r <= 1'b0;
          if (in_polygon_sel) cnt_b_r <= '0;
          else                cnt_a_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        hit_r   <= 1'b0;
        dir_x_r <= '0;
        dir_y_r <= '0;
        start_r <= '0;
        i_r     <= '0;
        j_r     <= '0;
        ovf_r   <= dropped_r;
      end
      S_RA1: pa0_r <= rd_q_r;
      S_RB0: pa1_r <= rd_q_r;
      S_RB1: pb0_r <= rd_q_r;
      S_CAP: begin
        pb1_r <= rd_q_r;
        op_r  <= OP_D0;
      end
      S_MGO: begin
        neg_r <= mul_neg;
        if (op_r == OP_SX) start_r <= rd_q_r;
      end
      S_MWT: begin
        if (mul_done) begin
          case (op_r)
            OP_D0: begin acc_r <= sp;     op_r <= OP_D1; end
            OP_D1: begin d_r   <= d_diff; op_r <= OP_T0; end
            OP_T0: begin acc_r <= sp;     op_r <= OP_T1; end
            OP_T1: begin tn_r  <= d_diff; op_r <= OP_U0; end
            OP_U0: begin acc_r <= sp;     op_r <= OP_U1; end
            OP_U1: un_r <= d_diff;
            OP_SX: begin s_r <= mul_p[MA_W-1:0]; op_r <= OP_SY; end
            OP_SY: begin
              s_r    <= s_r + mul_p[MA_W-1:0];
              op_r   <= OP_C2;
              comp_r <= 1'b0;
            end
            OP_C2: begin
              rhs_r <= {mul_p[65:0], 30'd0};
              lo_r  <= '0;
              hi_r  <= Q_ONE;
            end
            OP_KK: begin
              if (kk_fits) lo_r <= mid_r;
              else         hi_r <= mid_r - 15'd1;
            end
            default: ;
          endcase
        end
      end
      S_NORM: begin
        if (d_r[67]) begin
          d_r  <= -d_r;
          tn_r <= -tn_r;
          un_r <= -un_r;
        end
      end
      S_TEST: begin
        rt_r <= d_r - tn_r;
        ru_r <= d_r - un_r;
      end
      S_MIN: begin
        mt_r <= (rt_r < tn_r) ? rt_r : tn_r;
        mu_r <= (ru_r < un_r) ? ru_r : un_r;
      end
      S_PICK: begin
        op_r <= OP_SX;
        if (b_side) begin
          vx_r   <= 34'(eay);
          vy_r   <= -34'(eax);
          pick_r <= (d_r < un2) ? ib1 : ib;
        end else begin
          vx_r   <= -34'(eby);
          vy_r   <= 34'(ebx);
          pick_r <= (d_r < tn2) ? ia1 : ia;
        end
      end
      S_BS: begin
        if (bs_more) begin
          mid_r <= mid;
        end else if (!comp_r) begin
          dir_x_r <= qv;
          comp_r  <= 1'b1;
          op_r    <= OP_C2;
        end else begin
          dir_y_r <= qv;
          hit_r   <= 1'b1;
        end
      end
      S_KK: begin
        kk_r <= 32'(kodd * kodd);
        op_r <= OP_KK;
      end
      S_NEXT: begin
        if (j_last) begin
          j_r <= '0;
          i_r <= i1;
        end else begin
          j_r <= j1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_hit_r     <= hit_r;
      out_dir_x_r   <= dir_x_r;
      out_dir_y_r   <= dir_y_r;
      out_start_x_r <= start_r[31:0];
      out_start_y_r <= start_r[63:32];
      out_ovf_r     <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_dir_x    = out_dir_x_r;
  assign out_dir_y    = out_dir_y_r;
  assign out_start_x  = out_start_x_r;
  assign out_start_y  = out_start_y_r;
  assign out_overflow = out_ovf_r;

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CW'(MAX_VERTICES)) && (cnt_b_r <= CW'(MAX_VERTICES)))
    else $error("vertex count beyond capacity");

  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MWT)
    else $error("multiplier finished outside wait state");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish state");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_TEST) |=> !in_ready)
    else $error("input taken while a test runs");

endmodule

// ===== tb/sv/polygon_edge_intersection_unit_tb.sv =====
// Self-checking testbench for polygon_edge_intersection_unit: random and directed
// append/test/clear beats, results checked against an in-bench crossing predictor.
// Depends on pei_pkg and the unit itself.
`timescale 1ns / 1ps

module polygon_edge_intersection_unit_tb
  import pei_pkg::*;
();

  localparam int NV = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // reserved code, must be ignored

  typedef logic signed [127:0] wide_t;

  // one result beat
  typedef struct packed {
    logic               hit;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic               overflow;
  } crossing_t;

  // Tracks polygon contents and predicts each test result.
  class crossing_scoreboard_t;
    logic [63:0] verts[2*NV];
    int unsigned nverts[2];
    bit          dropped;
    crossing_t   expected_q[$];
    int          mismatches;

    function new();
      nverts[0] = 0;
      nverts[1] = 0;
      dropped = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function wide_t cx(int idx);
      wide_t v;
      v = $signed(verts[idx][31:0]);
      return v;
    endfunction

    function wide_t cy(int idx);
      wide_t v;
      v = $signed(verts[idx][63:32]);
      return v;
    endfunction

    // Q1.14 component: largest q with (2q-1)^2 * |v|^2 <= 2^30 * c^2
    function logic signed [15:0] unit_comp(wide_t c, wide_t sumsq);
      wide_t mc, rhs, k;
      int lo, hi, mid;
      mc = (c < 0) ? -c : c;
      rhs = (mc * mc) <<< 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        k = 2 * mid - 1;
        if (sumsq * k * k <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return 16'((c < 0) ? -lo : lo);
    endfunction

    function crossing_t run_test();
      crossing_t r;
      int na, nb, ia, ia1, ib, ib1, pick;
      wide_t ax, ay, eax, eay, bx, by, ebx, eby, dx, dy;
      wide_t d, tn, un, mt, mu, rest, vx, vy, s;
      r = '0;
      r.overflow = dropped;
      na = nverts[0];
      nb = nverts[1];
      for (int i = 0; i < na; i++) begin
        ia = i;
        ia1 = (i + 1 < na) ? i + 1 : 0;
        ax = cx(ia); ay = cy(ia);
        eax = cx(ia1) - ax; eay = cy(ia1) - ay;
        for (int j = 0; j < nb; j++) begin
          ib = NV + j;
          ib1 = NV + ((j + 1 < nb) ? j + 1 : 0);
          bx = cx(ib); by = cy(ib);
          ebx = cx(ib1) - bx; eby = cy(ib1) - by;
          dx = bx - ax; dy = by - ay;
          d = eax * eby - eay * ebx;
          if (d == 0) continue;  // parallel or zero-length edge
          tn = dx * eby - dy * ebx;
          un = dx * eay - dy * eax;
          if (d < 0) begin
            d = -d; tn = -tn; un = -un;
          end
          if (!(tn > 0 && tn < d && un > 0 && un < d)) continue;
          rest = d - tn; mt = (rest < tn) ? rest : tn;
          rest = d - un; mu = (rest < un) ? rest : un;
          if (mu < mt) begin
            vx = eay; vy = -eax;
            pick = (d < un + un) ? ib1 : ib;
          end else begin  // ties land here
            vx = -eby; vy = ebx;
            pick = (d < tn + tn) ? ia1 : ia;
          end
          s = vx * vx + vy * vy;
          r.hit = 1'b1;
          r.dir_x = unit_comp(vx, s);
          r.dir_y = unit_comp(vy, s);
          r.start_x = verts[pick][31:0];
          r.start_y = verts[pick][63:32];
          return r;
        end
      end
      return r;
    endfunction

    function void note_input(logic [1:0] cmd, logic sel, logic [31:0] x, logic [31:0] y);
      case (cmd)
        CMD_APPEND: begin
          if (nverts[sel] < NV) begin
            verts[sel * NV + nverts[sel]] = {y, x};
            nverts[sel]++;
          end else begin
            dropped = 1;
          end
        end
        CMD_CLEAR: begin
          nverts[sel] = 0;
          dropped = 0;
        end
        CMD_TEST: expected_q = {expected_q, run_test()};
        default: ;
      endcase
    endfunction

    function void check_result(crossing_t got);
      crossing_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_command;
  logic in_polygon_sel;
  logic signed [31:0] in_vertex_x, in_vertex_y;
  logic out_valid, out_ready, out_hit, out_overflow;
  logic signed [15:0] out_dir_x, out_dir_y;
  logic signed [31:0] out_start_x, out_start_y;

  crossing_scoreboard_t sb = new();
  bit quiet = 0;           // no idling on either side
  int hold_cycles = 0;     // one-shot long receiver stall

  polygon_edge_intersection_unit #(.MAX_VERTICES(NV)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_polygon_sel(in_polygon_sel),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_dir_x(out_dir_x), .out_dir_y(out_dir_y),
    .out_start_x(out_start_x), .out_start_y(out_start_y),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Monitors: sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_command, in_polygon_sel, in_vertex_x, in_vertex_y);
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_hit, out_dir_x, out_dir_y, out_start_x, out_start_y,
                       out_overflow});
  end

  // Receiver: random ready bursts, plus the long hold when requested.
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_ready = 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ready = 1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  // One input beat; called at a falling edge, returns at a falling edge.
  task automatic send(input logic [1:0] cmd, input logic sel,
                      input logic [31:0] x, input logic [31:0] y);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1;
    in_command = cmd;
    in_polygon_sel = sel;
    in_vertex_x = x;
    in_vertex_y = y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic add_vertex(input logic sel, input int x, input int y);
    send(CMD_APPEND, sel, x, y);
  endtask

  // waits at falling edges until every expected result has come back
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // mostly near the origin so polygons overlap; sometimes full range
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return $signed($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  // One well-formed round: clear both, fill both, test one or more times.
  task automatic random_round();
    int n;
    send(CMD_CLEAR, 0, $urandom(), $urandom());
    send(CMD_CLEAR, 1, $urandom(), $urandom());
    for (int p = 0; p < 2; p++) begin
      n = ($urandom_range(0, 14) == 0) ? $urandom_range(NV, NV + 2) : $urandom_range(0, 6);
      for (int k = 0; k < n; k++) send(CMD_APPEND, 1'(p), pick_coord(), pick_coord());
    end
    repeat ($urandom_range(1, 2)) send(CMD_TEST, 1'($urandom()), $urandom(), $urandom());
    // noise
    if ($urandom_range(0, 3) == 0)
      send(2'($urandom()), 1'($urandom()), $urandom(), $urandom());
  endtask

  initial begin
    in_valid = 0;
    in_command = CMD_APPEND;
    in_polygon_sel = 0;
    in_vertex_x = 0;
    in_vertex_y = 0;
    rst_n = 0;
    repeat (7) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // --- directed part ---
    send(CMD_TEST, 0, 0, 0);                 // both empty: no hit
    add_vertex(0, 0, 0);                     // A single vertex: zero-length edge
    send(CMD_TEST, 1, 32'hffff_ffff, 32'hffff_ffff);
    add_vertex(0, 32'h0002_0000, 0);         // A: segment (0,0)-(2,0)
    add_vertex(1, 32'h0001_0000, 32'hffff_0000);
    add_vertex(1, 32'h0001_0000, 32'h0001_0000);  // B crosses at both midpoints: tie
    send(CMD_TEST, 0, 0, 0);
    send(CMD_CLEAR, 1, 0, 0);
    add_vertex(1, 0, 32'h0001_0000);         // B parallel to A
    add_vertex(1, 32'h0003_0000, 32'h0001_0000);
    send(CMD_TEST, 0, 0, 0);
    send(CMD_UNUSED, 1, 32'h5555_5555, 32'haaaa_aaaa);  // ignored
    send(CMD_CLEAR, 0, 0, 0);
    add_vertex(0, 32'h8000_0000, 32'h8000_0000);   // extreme corners
    add_vertex(0, 32'h7fff_ffff, 32'h7fff_ffff);
    add_vertex(0, 32'h8000_0000, 32'h7fff_ffff);
    send(CMD_CLEAR, 1, 0, 0);
    add_vertex(1, 32'h7fff_ffff, 32'h8000_0000);
    add_vertex(1, 32'h8000_0000, 32'h7fff_fff0);
    add_vertex(1, 32'h0000_0001, 32'h0000_0000);
    send(CMD_TEST, 0, 0, 0);
    for (int k = 0; k < NV + 1; k++)        // fill B past the top: dropped beat
      add_vertex(1, k * 32'h0000_1000, (k % 3) * 32'h0001_0000);
    send(CMD_TEST, 0, 0, 0);
    in_valid = 0;

    // sender waits out every pending result
    drain();
    @(negedge clk);

    // long receiver stall while tests keep coming, so the input backs up
    hold_cycles = 3000;
    for (int r = 0; r < 3; r++) random_round();

    // --- random part ---
    for (int r = 0; r < 34; r++) random_round();
    quiet = 1;
    for (int r = 0; r < 6; r++) random_round();
    in_valid = 0;

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pei_pkg.sv
src/pei_mul.sv
src/polygon_edge_intersection_unit.sv
tb/sv/polygon_edge_intersection_unit_tb.sv
